// File: hw/rtl/bracket_balance_checker_defines.svh
// Assertion macros for the bracket balance checker.
// Used by the checker module; no other dependencies.
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bbc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bbc assertion failed");

`endif

// File: hw/rtl/bbc_pkg.sv
// Shared types, constants and decode functions for the bracket balance checker.
// No dependencies.
package bbc_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] CH_OPEN_PAREN   = 8'h28; // (
	localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29; // )
	localparam logic [7:0] CH_OPEN_BRACE   = 8'h7B; // {
	localparam logic [7:0] CH_CLOSE_BRACE  = 8'h7D; // }
	localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B; // [
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D; // ]

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_PAREN  = 2'd0;
	localparam kind_t KIND_BRACE  = 2'd1;
	localparam kind_t KIND_SQUARE = 2'd2;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_MISMATCH = 3'd1,
		ERR_EMPTY    = 3'd2,
		ERR_UNCLOSED = 3'd3,
		ERR_OVERFLOW = 3'd4
	} err_kind_t;

	typedef struct packed {
		logic  hit;
		kind_t kind;
	} bracket_t;

	// Shift command broadcast along the cell chain.
	typedef struct packed {
		logic  push;
		logic  pop;
		kind_t kind;
	} stack_op_t;

	typedef struct packed {
		logic      is_valid;
		err_kind_t error_kind;
	} verdict_t;

	function automatic bracket_t open_kind(input logic [7:0] c);
		bracket_t r;
		r.hit  = 1'b1;
		r.kind = KIND_PAREN;
		if (c == CH_OPEN_PAREN) begin
			r.kind = KIND_PAREN;
		end else if (c == CH_OPEN_BRACE) begin
			r.kind = KIND_BRACE;
		end else if (c == CH_OPEN_SQUARE) begin
			r.kind = KIND_SQUARE;
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

	function automatic bracket_t close_kind(input logic [7:0] c);
		bracket_t r;
		r.hit  = 1'b1;
		r.kind = KIND_PAREN;
		if (c == CH_CLOSE_PAREN) begin
			r.kind = KIND_PAREN;
		end else if (c == CH_CLOSE_BRACE) begin
			r.kind = KIND_BRACE;
		end else if (c == CH_CLOSE_SQUARE) begin
			r.kind = KIND_SQUARE;
		end else begin
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/bbc_if.sv
// Valid/ready channel interfaces for characters in and verdicts out.
// No package dependencies.
interface bbc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       last_char;

	modport source (output valid, output char_byte, output last_char, input ready);
	modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

interface bbc_verdict_if;
	logic       valid;
	logic       ready;
	logic       is_valid;
	logic [2:0] error_kind;

	modport source (output valid, output is_valid, output error_kind, input ready);
	modport sink   (input valid, input is_valid, input error_kind, output ready);
endinterface

// File: hw/rtl/bbc_cell.sv
// One stack cell of the shift-register stack.
// Depends on bbc_pkg.
module bbc_cell (
	input  logic              clk,
	input  bbc_pkg::stack_op_t op,
	input  bbc_pkg::kind_t    from_above,
	input  bbc_pkg::kind_t    from_below,
	output bbc_pkg::kind_t    kind
);

	bbc_pkg::kind_t kind_q;

	// Push: take the entry above; pop: take the entry below; else hold.
	always_ff @(posedge clk) begin
		if (op.push) begin
			kind_q <= from_above;
		end else if (op.pop) begin
			kind_q <= from_below;
		end
	end

	assign kind = kind_q;

endmodule

// File: hw/rtl/bbc_ctrl.sv
// Stack depth counter, sticky error and verdict logic.
// Depends on bbc_pkg.
module bbc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           char_byte,
	input  logic                 last_char,
	input  bbc_pkg::kind_t       top_kind,
	output bbc_pkg::stack_op_t   op,
	output bbc_pkg::verdict_t    verdict
);

	logic [bbc_pkg::CNT_W-1:0] count_q, count_d;
	bbc_pkg::err_kind_t        err_q, err_d;
	bbc_pkg::bracket_t         opn, cls;
	bbc_pkg::err_kind_t        code;

	always_comb begin
		opn     = bbc_pkg::open_kind(char_byte);
		cls     = bbc_pkg::close_kind(char_byte);
		op.push = 1'b0;
		op.pop  = 1'b0;
		op.kind = opn.kind;
		count_d = count_q;
		err_d   = err_q;
		if (accept && err_q == bbc_pkg::ERR_NONE) begin
			priority if (opn.hit) begin
				if (count_q == bbc_pkg::CNT_W'(bbc_pkg::STACK_DEPTH)) begin
					err_d = bbc_pkg::ERR_OVERFLOW;
				end else begin
					op.push = 1'b1;
					count_d = count_q + 1'b1;
				end
			end else if (cls.hit) begin
				if (count_q == '0) begin
					err_d = bbc_pkg::ERR_EMPTY;
				end else if (top_kind == cls.kind) begin
					op.pop  = 1'b1;
					count_d = count_q - 1'b1;
				end else begin
					err_d = bbc_pkg::ERR_MISMATCH;
				end
			end else begin
				err_d = err_q;
			end
		end

		// Verdict: recorded error first, then unclosed opens.
		if (err_d != bbc_pkg::ERR_NONE) begin
			code = err_d;
		end else if (count_d != '0) begin
			code = bbc_pkg::ERR_UNCLOSED;
		end else begin
			code = bbc_pkg::ERR_NONE;
		end
		verdict.is_valid   = (code == bbc_pkg::ERR_NONE);
		verdict.error_kind = code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= bbc_pkg::ERR_NONE;
		end else if (accept && last_char) begin
			count_q <= '0;
			err_q   <= bbc_pkg::ERR_NONE;
		end else begin
			count_q <= count_d;
			err_q   <= err_d;
		end
	end

endmodule

// File: hw/rtl/bracket_balance_checker.sv
// Bracket balance checker: takes one character per item on the chars channel, with
// last_char marking the end of a message, and returns one verdict item per message on
// the verdicts channel: is_valid, or an error_kind of mismatched close, close on empty
// stack, opens left unclosed, or overflow beyond STACK_DEPTH open brackets. The first
// error of a message is sticky and later characters are ignored until the last one,
// after which the state is cleared for the next message. Throughput is one character
// per clock while chars.ready is high: the stack is a chain of STACK_DEPTH cells that
// all shift by one place in the same cycle. With the result queue empty, a verdict
// appears on the output in the cycle after its last character is taken. A two-item
// result queue decouples the sides, so characters keep flowing while one verdict waits;
// chars.ready drops only when two verdicts are waiting. No clearing pass is needed
// after reset.
// Depends on bbc_pkg, bbc_if, bbc_cell and bbc_ctrl.
module bracket_balance_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	bbc_char_if.sink             chars,
	bbc_verdict_if.source        verdicts
);

	logic               accept;
	bbc_pkg::stack_op_t op;
	bbc_pkg::verdict_t  verdict;
	bbc_pkg::kind_t     cell_kind [bbc_pkg::STACK_DEPTH];

	// Result queue: slot0 is the head shown on the output.
	bbc_pkg::verdict_t  slot0_q, slot1_q;
	logic [1:0]         fill_q;
	logic               push_res, pop_res;

	assign chars.ready = (fill_q != 2'd2);
	assign accept      = chars.valid && chars.ready;

	bbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_byte (chars.char_byte),
		.last_char (chars.last_char),
		.top_kind  (cell_kind[0]),
		.op        (op),
		.verdict   (verdict)
	);

	// Cell 0 is the top of stack; a push shifts every entry one place down.
	for (genvar i = 0; i < bbc_pkg::STACK_DEPTH; i++) begin : g_cell
		bbc_pkg::kind_t above, below;
		if (i == 0) begin : g_top
			assign above = op.kind;
		end else begin : g_mid_top
			assign above = cell_kind[i-1];
		end
		if (i == bbc_pkg::STACK_DEPTH - 1) begin : g_bot
			assign below = cell_kind[i];
		end else begin : g_mid_bot
			assign below = cell_kind[i+1];
		end
		bbc_cell u_cell (
			.clk        (clk),
			.op         (op),
			.from_above (above),
			.from_below (below),
			.kind       (cell_kind[i])
		);
	end

	assign push_res = accept && chars.last_char;
	assign pop_res  = verdicts.valid && verdicts.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else begin
			fill_q <= fill_q + {1'b0, push_res} - {1'b0, pop_res};
		end
	end

	// Advance the queue on a pop, fill the first free slot on a push.
	always_ff @(posedge clk) begin
		if (pop_res) begin
			if (push_res && fill_q == 2'd1) begin
				slot0_q <= verdict;
			end else begin
				slot0_q <= slot1_q;
			end
			if (push_res && fill_q == 2'd2) begin
				slot1_q <= verdict;
			end
		end else if (push_res) begin
			if (fill_q == 2'd0) begin
				slot0_q <= verdict;
			end else begin
				slot1_q <= verdict;
			end
		end
	end

	assign verdicts.valid      = (fill_q != 2'd0);
	assign verdicts.is_valid   = slot0_q.is_valid;
	assign verdicts.error_kind = slot0_q.error_kind;

endmodule

// File: hw/rtl/bbc_checker.sv
// Port-level assertions for the bracket balance checker, bound to the top level.
// Depends on bbc_pkg and bracket_balance_checker_defines.svh.
`include "bracket_balance_checker_defines.svh"

module bbc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       chars_valid,
	input logic       chars_ready,
	input logic       chars_last_char,
	input logic       verdicts_valid,
	input logic       verdicts_ready,
	input logic       verdicts_is_valid,
	input logic [2:0] verdicts_error_kind
);

	`BBC_ASSERT_NOW(a_valid_iff_none, clk, arst_n, verdicts_valid, verdicts_is_valid == (verdicts_error_kind == bbc_pkg::ERR_NONE))
	`BBC_ASSERT_NOW(a_code_in_range, clk, arst_n, verdicts_valid, verdicts_error_kind == bbc_pkg::ERR_NONE || verdicts_error_kind == bbc_pkg::ERR_MISMATCH || verdicts_error_kind == bbc_pkg::ERR_EMPTY || verdicts_error_kind == bbc_pkg::ERR_UNCLOSED || verdicts_error_kind == bbc_pkg::ERR_OVERFLOW)
	`BBC_ASSERT_NEXT(a_last_gives_verdict, clk, arst_n, chars_valid && chars_ready && chars_last_char, verdicts_valid)
	`BBC_ASSERT_NEXT(a_stall_holds, clk, arst_n, verdicts_valid && !verdicts_ready, verdicts_valid && $stable(verdicts_is_valid) && $stable(verdicts_error_kind))

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.chars_valid         (chars.valid),
	.chars_ready         (chars.ready),
	.chars_last_char     (chars.last_char),
	.verdicts_valid      (verdicts.valid),
	.verdicts_ready      (verdicts.ready),
	.verdicts_is_valid   (verdicts.is_valid),
	.verdicts_error_kind (verdicts.error_kind)
);
